### rtl/complex_arith_unit_top_macros.svh
// assertion macros for the complex arithmetic unit checker
// no dependencies; included by the checker file
`ifndef COMPLEX_ARITH_UNIT_TOP_MACROS_SVH
`define COMPLEX_ARITH_UNIT_TOP_MACROS_SVH

// clocked assertion, quiet while reset is asserted
`define CAU_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked assertion that is also checked during reset
`define CAU_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/cau_pkg.sv
// shared types, widths and saturation helper for the complex arithmetic unit
// no dependencies
package cau_pkg;

    localparam int DATA_WIDTH = 16;
    localparam int FRAC_BITS  = 8;

    localparam int PROD_W = 2 * DATA_WIDTH;          // one operand product
    localparam int SUM_W  = PROD_W + 1;              // sum of two products
    localparam int MAG_W  = PROD_W;                  // magnitude of a product sum
    localparam int D_W    = PROD_W;                  // |b|^2
    localparam int QBITS  = DATA_WIDTH + 1;          // quotient bits kept
    localparam int REM_W  = D_W + QBITS;             // partial remainder

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2,
        CMD_DIV = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_DIVZ = 2'd2
    } t_status;

    // word carried along the divider stages
    typedef struct packed {
        logic                  is_div;
        logic                  neg_re;
        logic                  neg_im;
        logic                  ovf_re;
        logic                  ovf_im;
        logic [REM_W-1:0]      rem_re;
        logic [REM_W-1:0]      rem_im;
        logic [REM_W-1:0]      dtop;
        logic [QBITS-1:0]      q_re;
        logic [QBITS-1:0]      q_im;
        logic [DATA_WIDTH-1:0] res_re;
        logic [DATA_WIDTH-1:0] res_im;
        t_status               status;
    } t_word;

    typedef struct packed {
        logic                  flag;
        logic [DATA_WIDTH-1:0] value;
    } t_sat;

    localparam logic signed [SUM_W-1:0] SAT_MAX =
        {{(SUM_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_MIN =
        {{(SUM_W-DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}};

    function automatic t_sat sat_val(input logic signed [SUM_W-1:0] v);
        t_sat r;
        r.flag  = 1'b0;
        r.value = v[DATA_WIDTH-1:0];
        if (v > SAT_MAX) begin
            r.flag  = 1'b1;
            r.value = SAT_MAX[DATA_WIDTH-1:0];
        end else if (v < SAT_MIN) begin
            r.flag  = 1'b1;
            r.value = SAT_MIN[DATA_WIDTH-1:0];
        end
        return r;
    endfunction

endpackage

### rtl/cau_front.sv
// operand products, add/sub/mul results and divider setup (three stages)
// depends on cau_pkg
module cau_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  logic [1:0]                     i_command,
    input  logic signed [cau_pkg::DATA_WIDTH-1:0] i_a_real,
    input  logic signed [cau_pkg::DATA_WIDTH-1:0] i_a_imag,
    input  logic signed [cau_pkg::DATA_WIDTH-1:0] i_b_real,
    input  logic signed [cau_pkg::DATA_WIDTH-1:0] i_b_imag,
    output logic                           o_valid,
    output cau_pkg::t_word                 o_word
);
    import cau_pkg::*;

    // stage 1: products and add/sub
    logic                     r1_valid;
    t_cmd                     r1_cmd;
    logic signed [PROD_W-1:0] r1_prr, r1_pii, r1_pri, r1_pir, r1_bb, r1_ii;
    logic signed [DATA_WIDTH:0] r1_as_re, r1_as_im;

    logic signed [PROD_W-1:0] n1_prr, n1_pii, n1_pri, n1_pir, n1_bb, n1_ii;
    logic signed [DATA_WIDTH:0] n1_as_re, n1_as_im;

    always_comb begin
        n1_prr = i_a_real * i_b_real;
        n1_pii = i_a_imag * i_b_imag;
        n1_pri = i_a_real * i_b_imag;
        n1_pir = i_a_imag * i_b_real;
        n1_bb  = i_b_real * i_b_real;
        n1_ii  = i_b_imag * i_b_imag;
        if (t_cmd'(i_command) == CMD_SUB) begin
            n1_as_re = (DATA_WIDTH+1)'(i_a_real) - (DATA_WIDTH+1)'(i_b_real);
            n1_as_im = (DATA_WIDTH+1)'(i_a_imag) - (DATA_WIDTH+1)'(i_b_imag);
        end else begin
            n1_as_re = (DATA_WIDTH+1)'(i_a_real) + (DATA_WIDTH+1)'(i_b_real);
            n1_as_im = (DATA_WIDTH+1)'(i_a_imag) + (DATA_WIDTH+1)'(i_b_imag);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
        end
        if (i_en) begin
            r1_cmd   <= t_cmd'(i_command);
            r1_prr   <= n1_prr;
            r1_pii   <= n1_pii;
            r1_pri   <= n1_pri;
            r1_pir   <= n1_pir;
            r1_bb    <= n1_bb;
            r1_ii    <= n1_ii;
            r1_as_re <= n1_as_re;
            r1_as_im <= n1_as_im;
        end
    end

    // stage 2: product sums, final add/sub/mul result, dividend magnitudes
    logic                     r2_valid;
    logic                     r2_is_div, r2_neg_re, r2_neg_im;
    logic [MAG_W-1:0]         r2_mag_re, r2_mag_im;
    logic [D_W-1:0]           r2_d;
    logic [DATA_WIDTH-1:0]    r2_res_re, r2_res_im;
    t_status                  r2_status;

    logic signed [SUM_W-1:0]  m_re, m_im, v_re, v_im, dn_re, dn_im, abs_re, abs_im;
    logic [D_W-1:0]           n2_d;
    t_sat                     s_re, s_im;
    logic                     n2_is_div;
    logic [DATA_WIDTH-1:0]    n2_res_re, n2_res_im;
    t_status                  n2_status;

    always_comb begin
        m_re  = SUM_W'(r1_prr) - SUM_W'(r1_pii);
        m_im  = SUM_W'(r1_pri) + SUM_W'(r1_pir);
        dn_re = SUM_W'(r1_prr) + SUM_W'(r1_pii);
        dn_im = SUM_W'(r1_pir) - SUM_W'(r1_pri);
        abs_re = dn_re[SUM_W-1] ? -dn_re : dn_re;
        abs_im = dn_im[SUM_W-1] ? -dn_im : dn_im;
        n2_d  = D_W'(r1_bb) + D_W'(r1_ii);
        if (r1_cmd == CMD_MUL) begin
            v_re = m_re >>> FRAC_BITS;
            v_im = m_im >>> FRAC_BITS;
        end else begin
            v_re = SUM_W'(r1_as_re);
            v_im = SUM_W'(r1_as_im);
        end
        s_re = sat_val(v_re);
        s_im = sat_val(v_im);
        n2_is_div = 1'b0;
        n2_res_re = s_re.value;
        n2_res_im = s_im.value;
        n2_status = (s_re.flag || s_im.flag) ? ST_SAT : ST_OK;
        if (r1_cmd == CMD_DIV) begin
            if (n2_d == '0) begin
                n2_res_re = '0;
                n2_res_im = '0;
                n2_status = ST_DIVZ;
            end else begin
                n2_is_div = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r2_valid <= r1_valid;
        end
        if (i_en) begin
            r2_is_div <= n2_is_div;
            r2_neg_re <= dn_re[SUM_W-1];
            r2_neg_im <= dn_im[SUM_W-1];
            r2_mag_re <= abs_re[MAG_W-1:0];
            r2_mag_im <= abs_im[MAG_W-1:0];
            r2_d      <= n2_d;
            r2_res_re <= n2_res_re;
            r2_res_im <= n2_res_im;
            r2_status <= n2_status;
        end
    end

    // stage 3: quotient range check and divider load
    logic                     r3_valid;
    t_word                    r3_word;
    t_word                    n3_word;
    logic [REM_W-1:0]         num_re, num_im, dlim;

    always_comb begin
        num_re = REM_W'({r2_mag_re, {FRAC_BITS{1'b0}}});
        num_im = REM_W'({r2_mag_im, {FRAC_BITS{1'b0}}});
        dlim   = {r2_d, {QBITS{1'b0}}};
        n3_word.is_div = r2_is_div;
        n3_word.neg_re = r2_neg_re;
        n3_word.neg_im = r2_neg_im;
        // quotient would not fit the kept bits: clamps either way
        n3_word.ovf_re = num_re >= dlim;
        n3_word.ovf_im = num_im >= dlim;
        n3_word.rem_re = num_re;
        n3_word.rem_im = num_im;
        n3_word.dtop   = REM_W'(r2_d) << (QBITS-1);
        n3_word.q_re   = '0;
        n3_word.q_im   = '0;
        n3_word.res_re = r2_res_re;
        n3_word.res_im = r2_res_im;
        n3_word.status = r2_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r3_valid <= r2_valid;
        end
        if (i_en) begin
            r3_word <= n3_word;
        end
    end

    assign o_valid = r3_valid;
    assign o_word  = r3_word;

endmodule

### rtl/cau_div_stage.sv
// one restoring division step for both result parts
// depends on cau_pkg
module cau_div_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  cau_pkg::t_word i_word,
    output logic           o_valid,
    output cau_pkg::t_word o_word
);
    import cau_pkg::*;

    logic             r_valid;
    t_word            r_word;
    t_word            n_word;
    logic             ge_re, ge_im;
    logic [REM_W-1:0] rr_re, rr_im;

    always_comb begin
        ge_re  = i_word.rem_re >= i_word.dtop;
        ge_im  = i_word.rem_im >= i_word.dtop;
        rr_re  = ge_re ? (i_word.rem_re - i_word.dtop) : i_word.rem_re;
        rr_im  = ge_im ? (i_word.rem_im - i_word.dtop) : i_word.rem_im;
        n_word = i_word;
        n_word.rem_re = rr_re << 1;
        n_word.rem_im = rr_im << 1;
        n_word.q_re   = {i_word.q_re[QBITS-2:0], ge_re};
        n_word.q_im   = {i_word.q_im[QBITS-2:0], ge_im};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

### rtl/cau_out.sv
// quotient sign, saturation and the output register
// depends on cau_pkg
module cau_out (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  cau_pkg::t_word                i_word,
    output logic                          o_valid,
    output logic [cau_pkg::DATA_WIDTH-1:0] o_res_real,
    output logic [cau_pkg::DATA_WIDTH-1:0] o_res_imag,
    output cau_pkg::t_status              o_status
);
    import cau_pkg::*;

    logic                    r_valid;
    logic [DATA_WIDTH-1:0]   r_res_re, r_res_im;
    t_status                 r_status;

    logic signed [SUM_W-1:0] q_re, q_im;
    t_sat                    s_re, s_im;
    logic                    f_re, f_im;
    logic [DATA_WIDTH-1:0]   v_re, v_im;
    logic [DATA_WIDTH-1:0]   n_res_re, n_res_im;
    t_status                 n_status;

    always_comb begin
        q_re = SUM_W'(i_word.q_re);
        q_im = SUM_W'(i_word.q_im);
        if (i_word.neg_re) q_re = -q_re;
        if (i_word.neg_im) q_im = -q_im;
        s_re = sat_val(q_re);
        s_im = sat_val(q_im);
        f_re = s_re.flag;
        v_re = s_re.value;
        f_im = s_im.flag;
        v_im = s_im.value;
        if (i_word.ovf_re) begin
            f_re = 1'b1;
            v_re = i_word.neg_re ? SAT_MIN[DATA_WIDTH-1:0] : SAT_MAX[DATA_WIDTH-1:0];
        end
        if (i_word.ovf_im) begin
            f_im = 1'b1;
            v_im = i_word.neg_im ? SAT_MIN[DATA_WIDTH-1:0] : SAT_MAX[DATA_WIDTH-1:0];
        end
        if (i_word.is_div) begin
            n_res_re = v_re;
            n_res_im = v_im;
            n_status = (f_re || f_im) ? ST_SAT : ST_OK;
        end else begin
            n_res_re = i_word.res_re;
            n_res_im = i_word.res_im;
            n_status = i_word.status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_res_re <= n_res_re;
            r_res_im <= n_res_im;
            r_status <= n_status;
        end
    end

    assign o_valid    = r_valid;
    assign o_res_real = r_res_re;
    assign o_res_imag = r_res_im;
    assign o_status   = r_status;

endmodule

### rtl/complex_arith_unit_top.sv
// Complex add, subtract, multiply and divide on signed Q8.8 operands with a
// saturated Q8.8 result and a status code (ok, saturated, divide by zero).
// One item is accepted every cycle while the output is not stalled. Behind
// three stages of products, sums and range check sits a restoring divider
// with one quotient bit per stage (17 stages), then the output register.
// All commands take the same path so results leave in input order. A stall
// on the output while a result is valid holds the whole pipeline and is
// passed straight to o_stall.
// depends on cau_pkg, cau_front, cau_div_stage, cau_out
module complex_arith_unit_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic [1:0]                            i_command,
    input  logic signed [cau_pkg::DATA_WIDTH-1:0] i_a_real,
    input  logic signed [cau_pkg::DATA_WIDTH-1:0] i_a_imag,
    input  logic signed [cau_pkg::DATA_WIDTH-1:0] i_b_real,
    input  logic signed [cau_pkg::DATA_WIDTH-1:0] i_b_imag,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [cau_pkg::DATA_WIDTH-1:0] o_res_real,
    output logic signed [cau_pkg::DATA_WIDTH-1:0] o_res_imag,
    output logic [1:0]                            o_status
);
    import cau_pkg::*;

    logic                  adv;
    logic                  s_valid [QBITS+1];
    t_word                 s_word  [QBITS+1];
    logic [DATA_WIDTH-1:0] res_re, res_im;
    t_status               status;

    // pipeline moves unless a finished result is held
    assign adv     = !(o_valid && i_stall);
    assign o_stall = !adv;

    cau_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (adv),
        .i_valid   (i_valid),
        .i_command (i_command),
        .i_a_real  (i_a_real),
        .i_a_imag  (i_a_imag),
        .i_b_real  (i_b_real),
        .i_b_imag  (i_b_imag),
        .o_valid   (s_valid[0]),
        .o_word    (s_word[0])
    );

    for (genvar g = 0; g < QBITS; g++) begin : g_div
        cau_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (adv),
            .i_valid (s_valid[g]),
            .i_word  (s_word[g]),
            .o_valid (s_valid[g+1]),
            .o_word  (s_word[g+1])
        );
    end

    cau_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (adv),
        .i_valid    (s_valid[QBITS]),
        .i_word     (s_word[QBITS]),
        .o_valid    (o_valid),
        .o_res_real (res_re),
        .o_res_imag (res_im),
        .o_status   (status)
    );

    assign o_res_real = $signed(res_re);
    assign o_res_imag = $signed(res_im);
    assign o_status   = status;

endmodule

### rtl/cau_checker.sv
// port-level checks for complex_arith_unit_top, attached by bind
// depends on cau_pkg and complex_arith_unit_top_macros.svh
`include "complex_arith_unit_top_macros.svh"

module cau_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_stall,
    input logic                         o_valid,
    input logic                         o_stall,
    input logic [cau_pkg::DATA_WIDTH-1:0] o_res_real,
    input logic [cau_pkg::DATA_WIDTH-1:0] o_res_imag,
    input logic [1:0]                   o_status
);
    import cau_pkg::*;

    localparam logic [DATA_WIDTH-1:0] LIM_HI = SAT_MAX[DATA_WIDTH-1:0];
    localparam logic [DATA_WIDTH-1:0] LIM_LO = SAT_MIN[DATA_WIDTH-1:0];

    // input side only backs up behind a held result
    `CAU_ASSERT(a_stall_cause, i_clk, i_rst_n, o_stall |-> (o_valid && i_stall), "o_stall without held result")

    `CAU_ASSERT(a_out_hold, i_clk, i_rst_n, (o_valid && i_stall) |=> (o_valid && $stable(o_res_real) && $stable(o_res_imag) && $stable(o_status)), "held result changed")

    `CAU_ASSERT(a_divz_zero, i_clk, i_rst_n, (o_valid && o_status == ST_DIVZ) |-> (o_res_real == '0 && o_res_imag == '0), "divide by zero result not zero")

    `CAU_ASSERT(a_sat_limit, i_clk, i_rst_n, (o_valid && o_status == ST_SAT) |-> (o_res_real == LIM_HI || o_res_real == LIM_LO || o_res_imag == LIM_HI || o_res_imag == LIM_LO), "saturation flagged without a clamped part")

    `CAU_ASSERT_RST(a_rst_empty, i_clk, !i_rst_n |=> !o_valid, "output valid after reset")

endmodule

bind complex_arith_unit_top cau_checker u_cau_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_stall    (i_stall),
    .o_valid    (o_valid),
    .o_stall    (o_stall),
    .o_res_real (o_res_real),
    .o_res_imag (o_res_imag),
    .o_status   (o_status)
);
